/* sv/ars_pkg.sv */
// Shared types, constants and codes for the ADC ratiometric scaler.
`timescale 1ns / 1ps

package ars_pkg;

  // Conversion resolution and field widths
  localparam int SAMPLE_BITS = 12;
  localparam int SMP_W       = 12;
  localparam int MODE_W      = 3;
  localparam int VALUE_W     = 34;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_USER_W  = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int RAW_W       = 12;
  localparam int TEMP_W      = 8;
  localparam int SUPPLY_W    = SAMPLE_BITS + 12;

  // Serial arithmetic units
  localparam int MUL_A_W   = 36;
  localparam int MUL_B_W   = 12;
  localparam int PROD_W    = 48;
  localparam int DIVD_W    = 48;
  localparam int DIVS_W    = 24;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  // Scaling constants
  localparam int REF_MV     = 2048;
  localparam int REF_SHIFT  = $clog2(REF_MV);
  localparam int SOLAR_DIV  = 10;
  localparam int OUTV_DIV   = 2;
  localparam int AMP_GAIN   = 59;
  localparam int SHUNT_MOHM = 10;
  localparam int CUR_GAIN   = AMP_GAIN * SHUNT_MOHM;
  localparam int OFFSET_UA  = 25000;
  localparam int UA_SCALE   = 1000000;
  localparam int TEMP_LIM   = 127;

  localparam logic [SMP_W-1:0]  S_MASK     = SMP_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [DIVD_W-1:0] SUPPLY_NUM = DIVD_W'(REF_MV * ((1 << SAMPLE_BITS) - 1));
  localparam logic [7:0]        TEMP_NEG   = 8'h80;
  localparam logic [7:0]        TEMP_MAG   = 8'h7F;

  // Channel kinds
  localparam logic [MODE_W-1:0] MODE_REF   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SOLAR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OUTV  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OUTI  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TEMP  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RAW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RAW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TEMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_MV = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_A,
    ST_MUL_C,
    ST_DIV_B,
    ST_FIN
  } ars_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* sv/ars_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module ars_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ars_pkg::MUL_A_W-1:0]  a,
  input  logic [ars_pkg::MUL_B_W-1:0]  b,
  output logic [ars_pkg::PROD_W-1:0]   prod,
  output ars_pkg::unit_stat_t          stat
);

  logic [ars_pkg::PROD_W-1:0]  a_r, a_nxt;
  logic [ars_pkg::MUL_B_W-1:0] b_r, b_nxt;
  logic [ars_pkg::PROD_W-1:0]  p_r, p_nxt;
  logic                        busy_r, done_r;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    p_nxt = p_r;
    if (start) begin
      a_nxt = ars_pkg::PROD_W'(a);
      b_nxt = b;
      p_nxt = '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        p_nxt = p_r + a_r;
      end
      a_nxt = a_r << 1;
      b_nxt = b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= (b != '0);
        done_r <= (b == '0);
      end else if (busy_r && (b_r[ars_pkg::MUL_B_W-1:1] == '0)) begin
        // last set bit consumed this cycle
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
  end

  assign prod      = p_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* sv/ars_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ars_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ars_pkg::DIVD_W-1:0]    dividend,
  input  logic [ars_pkg::DIVS_W-1:0]    divisor,
  output logic [ars_pkg::DIVD_W-1:0]    quotient,
  output ars_pkg::unit_stat_t           stat
);

  logic [ars_pkg::DIVS_W-1:0]    rem_r, rem_nxt;
  logic [ars_pkg::DIVD_W-1:0]    quo_r, quo_nxt;
  logic [ars_pkg::DIVS_W-1:0]    dv_r, dv_nxt;
  logic [ars_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, done_r;
  logic [ars_pkg::DIVS_W:0]      trial;
  logic                          ge;

  always_comb begin
    trial   = {rem_r, quo_r[ars_pkg::DIVD_W-1]};
    ge      = (trial >= {1'b0, dv_r});
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dv_nxt  = dv_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dv_nxt  = divisor;
      cnt_nxt = ars_pkg::DIV_CNT_W'(ars_pkg::DIVD_W - 1);
    end else if (busy_r) begin
      rem_nxt = ge ? ars_pkg::DIVS_W'(trial - {1'b0, dv_r}) : trial[ars_pkg::DIVS_W-1:0];
      quo_nxt = {quo_r[ars_pkg::DIVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dv_r  <= dv_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* sv/adc_ratiometric_scaler.sv */
// Top level of the ADC ratiometric scaler: sequencer, state, config and output register.
// An input item runs through the serial units by kind: reference, solar and output voltage
// use one divide of a 48-bit dividend; output current two serial multiplies by 12-bit factors,
// then one divide; temperature a multiply, a divide, a multiply by an 8-bit factor, a divide.
// Rejected items (zero divisor, unknown kind) skip the arithmetic and go straight to the result.
// One item at a time: a new transfer is taken only after the previous result is registered.
// Reset (synchronous, rst_n low) clears reference and supply and loads calibration defaults.
`timescale 1ns / 1ps

module adc_ratiometric_scaler (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ars_pkg::IN_DATA_W-1:0]      in_tdata,   // [11:0] sample
  input  logic [ars_pkg::MODE_W-1:0]         in_tuser,   // [2:0] mode
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ars_pkg::OUT_DATA_W-1:0]     out_tdata,  // [33:0] value
  output logic [ars_pkg::OUT_USER_W-1:0]     out_tuser,  // [2:0] kind, [3] error
  // configuration write port
  input  logic                               cfg_we,
  input  logic [ars_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ars_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // ---------------------------------------------------------------- state
  ars_pkg::ars_state_t state_r, state_nxt;

  logic [ars_pkg::MODE_W-1:0]   mode_r;
  logic [ars_pkg::SMP_W-1:0]    s_r;
  logic                         err_r;
  logic                         sign_r;
  logic [ars_pkg::PROD_W-1:0]   p1_r;
  logic [ars_pkg::RAW_W-1:0]    ref_r;
  logic [ars_pkg::SUPPLY_W-1:0] supply_r;

  // calibration registers
  logic [ars_pkg::RAW_W-1:0]    lo_raw_r, hi_raw_r, sup_cal_r;
  logic [ars_pkg::TEMP_W-1:0]   lo_temp_r, hi_temp_r;

  // output register
  logic                            out_valid_r;
  logic [ars_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic [ars_pkg::OUT_USER_W-1:0]  out_user_r;

  // ---------------------------------------------------------------- units
  logic                         mul_start, div_start;
  logic [ars_pkg::MUL_A_W-1:0]  mul_a;
  logic [ars_pkg::MUL_B_W-1:0]  mul_b;
  logic [ars_pkg::PROD_W-1:0]   mul_p;
  logic [ars_pkg::DIVD_W-1:0]   div_dvd, div_q;
  logic [ars_pkg::DIVS_W-1:0]   div_dvs;
  ars_pkg::unit_stat_t          mul_stat, div_stat;

  ars_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .stat  (mul_stat)
  );

  ars_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // ---------------------------------------------------------------- input side
  logic                       in_xfer;
  logic [ars_pkg::MODE_W-1:0] in_mode, cur_mode;
  logic [ars_pkg::SMP_W-1:0]  in_s, cur_s;
  logic                       cal_err;
  logic                       pre_err;

  assign in_tready = (state_r == ars_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_mode   = in_tuser;
  assign in_s      = in_tdata[ars_pkg::SMP_W-1:0] & ars_pkg::S_MASK;

  // In idle the operands come straight off the bus, later from the held item
  assign cur_mode = (state_r == ars_pkg::ST_IDLE) ? in_mode : mode_r;
  assign cur_s    = (state_r == ars_pkg::ST_IDLE) ? in_s : s_r;

  assign cal_err = (sup_cal_r == '0) || (lo_raw_r == hi_raw_r);

  // Decide up front whether the item is rejected without arithmetic
  always_comb begin
    unique case (in_mode) inside
      ars_pkg::MODE_REF:                                       pre_err = (in_s == '0);
      ars_pkg::MODE_SOLAR, ars_pkg::MODE_OUTV, ars_pkg::MODE_OUTI: pre_err = (ref_r == '0);
      ars_pkg::MODE_TEMP:                                      pre_err = cal_err;
      default:                                                 pre_err = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------- temperature terms
  logic signed [ars_pkg::DIVD_W:0] scaled_s, scaled_mag;
  logic signed [ars_pkg::TEMP_W:0] dtemp_s, dtemp_mag;
  logic signed [ars_pkg::RAW_W:0]  rawden_s, rawden_mag;
  logic                            sign_nxt;

  always_comb begin
    // scaled = s * supply / cal_supply - cal_low_raw; quotient sits in div_q after the first divide
    scaled_s   = $signed({1'b0, div_q}) - $signed({{(ars_pkg::DIVD_W + 1 - ars_pkg::RAW_W){1'b0}},
                                                   lo_raw_r});
    scaled_mag = scaled_s[ars_pkg::DIVD_W] ? -scaled_s : scaled_s;
    dtemp_s    = $signed({hi_temp_r[ars_pkg::TEMP_W-1], hi_temp_r})
               - $signed({lo_temp_r[ars_pkg::TEMP_W-1], lo_temp_r});
    dtemp_mag  = dtemp_s[ars_pkg::TEMP_W] ? -dtemp_s : dtemp_s;
    rawden_s   = $signed({1'b0, hi_raw_r}) - $signed({1'b0, lo_raw_r});
    rawden_mag = rawden_s[ars_pkg::RAW_W] ? -rawden_s : rawden_s;
    sign_nxt   = scaled_s[ars_pkg::DIVD_W] ^ dtemp_s[ars_pkg::TEMP_W] ^ rawden_s[ars_pkg::RAW_W];
  end

  // ---------------------------------------------------------------- sequencer
  logic fin_load;

  assign fin_load = (state_r == ars_pkg::ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ars_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (pre_err) begin
            state_nxt = ars_pkg::ST_FIN;
          end else if ((in_mode == ars_pkg::MODE_OUTI) || (in_mode == ars_pkg::MODE_TEMP)) begin
            state_nxt = ars_pkg::ST_MUL_A;
          end else begin
            state_nxt = ars_pkg::ST_DIV_A;
          end
        end
      end
      ars_pkg::ST_MUL_A: begin
        if (mul_stat.done) begin
          state_nxt = (mode_r == ars_pkg::MODE_OUTI) ? ars_pkg::ST_MUL_B : ars_pkg::ST_DIV_A;
        end
      end
      ars_pkg::ST_MUL_B: begin
        if (mul_stat.done) begin
          state_nxt = ars_pkg::ST_DIV_A;
        end
      end
      ars_pkg::ST_DIV_A: begin
        if (div_stat.done) begin
          state_nxt = (mode_r == ars_pkg::MODE_TEMP) ? ars_pkg::ST_MUL_C : ars_pkg::ST_FIN;
        end
      end
      ars_pkg::ST_MUL_C: begin
        if (mul_stat.done) begin
          state_nxt = ars_pkg::ST_DIV_B;
        end
      end
      ars_pkg::ST_DIV_B: begin
        if (div_stat.done) begin
          state_nxt = ars_pkg::ST_FIN;
        end
      end
      ars_pkg::ST_FIN: begin
        if (fin_load) begin
          state_nxt = ars_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ars_pkg::ST_IDLE;
    endcase
  end

  // Launch a unit on the edge that enters its step, with that step's operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    if (state_nxt != state_r) begin
      unique case (state_nxt)
        ars_pkg::ST_MUL_A: begin
          mul_start = 1'b1;
          mul_b     = cur_s;
          mul_a     = (cur_mode == ars_pkg::MODE_OUTI) ? ars_pkg::MUL_A_W'(ars_pkg::UA_SCALE)
                                                       : ars_pkg::MUL_A_W'(supply_r);
        end
        ars_pkg::ST_MUL_B: begin
          mul_start = 1'b1;
          mul_a     = ars_pkg::MUL_A_W'(ars_pkg::CUR_GAIN);
          mul_b     = ref_r;
        end
        ars_pkg::ST_MUL_C: begin
          mul_start = 1'b1;
          mul_a     = scaled_mag[ars_pkg::MUL_A_W-1:0];
          mul_b     = ars_pkg::MUL_B_W'(dtemp_mag[ars_pkg::TEMP_W-1:0]);
        end
        ars_pkg::ST_DIV_A: begin
          div_start = 1'b1;
          case (cur_mode)
            ars_pkg::MODE_REF: begin
              div_dvd = ars_pkg::SUPPLY_NUM;
              div_dvs = ars_pkg::DIVS_W'(cur_s);
            end
            ars_pkg::MODE_SOLAR: begin
              div_dvd = (ars_pkg::DIVD_W'(cur_s) * ars_pkg::DIVD_W'(ars_pkg::SOLAR_DIV))
                        << ars_pkg::REF_SHIFT;
              div_dvs = ars_pkg::DIVS_W'(ref_r);
            end
            ars_pkg::MODE_OUTV: begin
              div_dvd = (ars_pkg::DIVD_W'(cur_s) * ars_pkg::DIVD_W'(ars_pkg::OUTV_DIV))
                        << ars_pkg::REF_SHIFT;
              div_dvs = ars_pkg::DIVS_W'(ref_r);
            end
            ars_pkg::MODE_OUTI: begin
              div_dvd = p1_r << ars_pkg::REF_SHIFT;
              div_dvs = mul_p[ars_pkg::DIVS_W-1:0];
            end
            default: begin
              div_dvd = mul_p;
              div_dvs = ars_pkg::DIVS_W'(sup_cal_r);
            end
          endcase
        end
        ars_pkg::ST_DIV_B: begin
          div_start = 1'b1;
          div_dvd   = mul_p;
          div_dvs   = ars_pkg::DIVS_W'(rawden_mag[ars_pkg::RAW_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- result assembly
  logic [ars_pkg::VALUE_W-1:0]      q_sat, cur_val, value_fin;
  logic [ars_pkg::DIVD_W-1:0]       q_off;
  logic signed [ars_pkg::DIVD_W+1:0] t_full;
  logic [7:0]                       t_clip, t_byte;

  always_comb begin
    // saturate to the value field
    q_sat = (div_q[ars_pkg::DIVD_W-1:ars_pkg::VALUE_W] != '0) ? '1
          : div_q[ars_pkg::VALUE_W-1:0];

    // current: drop the amplifier offset, floor at zero
    q_off   = div_q - ars_pkg::DIVD_W'(ars_pkg::OFFSET_UA);
    cur_val = (div_q < ars_pkg::DIVD_W'(ars_pkg::OFFSET_UA)) ? '0
            : ((q_off[ars_pkg::DIVD_W-1:ars_pkg::VALUE_W] != '0) ? '1
               : q_off[ars_pkg::VALUE_W-1:0]);

    // temperature: apply quotient sign, add low cal point, clamp, encode sign-magnitude
    t_full = sign_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    t_full = t_full + $signed({{(ars_pkg::DIVD_W + 2 - ars_pkg::TEMP_W){lo_temp_r[7]}},
                               lo_temp_r});
    if (t_full > (ars_pkg::DIVD_W + 2)'(ars_pkg::TEMP_LIM)) begin
      t_clip = 8'(ars_pkg::TEMP_LIM);
    end else if (t_full < -$signed((ars_pkg::DIVD_W + 2)'(ars_pkg::TEMP_LIM))) begin
      t_clip = 8'(-ars_pkg::TEMP_LIM);
    end else begin
      t_clip = t_full[7:0];
    end
    t_byte = t_clip[7] ? (ars_pkg::TEMP_NEG | ((-t_clip) & ars_pkg::TEMP_MAG))
                       : (t_clip & ars_pkg::TEMP_MAG);

    case (mode_r) inside
      ars_pkg::MODE_REF, ars_pkg::MODE_SOLAR, ars_pkg::MODE_OUTV: value_fin = q_sat;
      ars_pkg::MODE_OUTI: value_fin = cur_val;
      ars_pkg::MODE_TEMP: value_fin = ars_pkg::VALUE_W'(t_byte);
      default:            value_fin = '0;
    endcase
    if (err_r) begin
      value_fin = '0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ars_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // held item and intermediate results
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= in_mode;
      s_r    <= in_s;
      err_r  <= pre_err;
    end
    if ((state_r == ars_pkg::ST_MUL_A) && mul_stat.done) begin
      p1_r <= mul_p;
    end
    if ((state_r == ars_pkg::ST_DIV_A) && div_stat.done) begin
      sign_r <= sign_nxt;
    end
  end

  // reference and supply: update when a reference result is committed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r    <= '0;
      supply_r <= '0;
    end else if (fin_load && (mode_r == ars_pkg::MODE_REF)) begin
      ref_r    <= s_r;
      supply_r <= err_r ? '0 : div_q[ars_pkg::SUPPLY_W-1:0];
    end
  end

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_raw_r  <= '0;
      hi_raw_r  <= 12'd4095;
      lo_temp_r <= 8'd30;
      hi_temp_r <= 8'd110;
      sup_cal_r <= 12'd3000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ars_pkg::CFG_LOW_RAW:   lo_raw_r  <= cfg_wdata;
        ars_pkg::CFG_HIGH_RAW:  hi_raw_r  <= cfg_wdata;
        ars_pkg::CFG_LOW_TEMP:  lo_temp_r <= cfg_wdata[ars_pkg::TEMP_W-1:0];
        ars_pkg::CFG_HIGH_TEMP: hi_temp_r <= cfg_wdata[ars_pkg::TEMP_W-1:0];
        ars_pkg::CFG_SUPPLY_MV: sup_cal_r <= cfg_wdata;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // output register: hold a result until its transfer, load the next one behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data_r <= ars_pkg::OUT_DATA_W'(value_fin);
      out_user_r <= {err_r, mode_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------------------------------------------------------- assertions
  // one item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken while an item is in flight");

  // the shared units are used in strict sequence
  a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and divider busy together");

  // flagged results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[3]) |-> (out_tdata == '0))
    else $error("error result with nonzero value");

  // temperature is a byte and never encodes negative zero
  a_temp_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[3] && (out_tuser[2:0] == ars_pkg::MODE_TEMP))
      |-> ((out_tdata[ars_pkg::OUT_DATA_W-1:8] == '0) && (out_tdata[7:0] != ars_pkg::TEMP_NEG)))
    else $error("temperature result out of range");

endmodule
